>>> design/sac_pkg.sv
// shared constants and codes for the swept box axis clamp
`timescale 1ns / 1ps

package sac_pkg;

  // coordinate format: signed, twelve fraction bits at the default width
  localparam int COORD_WIDTH = 32;

  localparam int TOL_WIDTH = 12;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 12'd4;

  // request kinds carried on in_tuser
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_BOX   = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // move axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // register map, word index taken from paddr[2]
  localparam int CFG_ADDR_WIDTH = 3;
  localparam logic REG_TOL = 1'b0;

endpackage

>>> design/swept_aabb_axis_clamp.sv
// top level: per-axis swept box clamp against a stream of obstacle boxes
`timescale 1ns / 1ps

// channel   | dir | handshake          | payload
// ----------+-----+--------------------+------------------------------------------
// in_       | in  | tvalid / tready    | tuser opcode, tdata axis, box, delta, ok
// out_      | out | tvalid / tready    | tdata allowed delta and three flags
// cfg_      | in  | apb, pready tied 1 | contact_tolerance at byte address 0
//
// one request per cycle sustained, limited only by the single result register;
// an end's result goes through the input register, then the result register
// in_tready drops only while an end request waits on a full result register
// rst_n is synchronous, active low; it empties both stages and restores the
// tolerance to four and the query state to the zero-move case

module swept_aabb_axis_clamp #(
  parameter int COORD_WIDTH = sac_pkg::COORD_WIDTH,
  localparam int IN_BITS  = 2 + 7 * COORD_WIDTH + 1,
  localparam int IN_DW    = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = COORD_WIDTH + 3,
  localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // low to high: move_axis, box_min_x, box_min_y, box_min_z,
  // box_max_x, box_max_y, box_max_z, move_delta, query_ok, zero fill
  input  logic [IN_DW-1:0]                   in_tdata,
  // opcode
  input  logic [1:0]                         in_tuser,
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // low to high: allowed_delta, hit, on_ground, zero_velocity, zero fill
  output logic [OUT_DW-1:0]                  out_tdata,
  // configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [sac_pkg::CFG_ADDR_WIDTH-1:0] cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int CW = COORD_WIDTH;
  // two guard bits make every sum and difference below exact
  localparam int W  = CW + 2;
  localparam int TW = sac_pkg::TOL_WIDTH;

  // ---------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------
  logic [TW-1:0] tol_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == sac_pkg::REG_TOL);
  assign cfg_prdata = (cfg_paddr[2] == sac_pkg::REG_TOL) ?
                      {{(32-TW){1'b0}}, tol_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= sac_pkg::TOL_RESET;
    end else if (cfg_wr) begin
      tol_r <= cfg_pwdata[TW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------
  logic                 s1_valid_r;
  logic [1:0]           s1_op_r;
  logic [1:0]           s1_axis_r;
  logic signed [CW-1:0] s1_box_r [6];
  logic signed [CW-1:0] s1_delta_r;
  logic                 s1_ok_r;

  logic out_valid_r;
  logic out_free;
  logic s1_adv;
  logic in_acc;

  assign out_free  = !out_valid_r || out_tready;
  // begin and box requests always retire; an end needs room for its result
  assign s1_adv    = s1_valid_r && ((s1_op_r != sac_pkg::OP_END) || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_tuser;
      s1_axis_r  <= in_tdata[1:0];
      for (int k = 0; k < 6; k++) begin
        s1_box_r[k] <= in_tdata[2 + k*CW +: CW];
      end
      s1_delta_r <= in_tdata[2 + 6*CW +: CW];
      s1_ok_r    <= in_tdata[2 + 7*CW];
    end
  end

  // ---------------------------------------------------------------------
  // query state
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] sbox_r [6];   // min x y z, then max x y z
  logic signed [CW-1:0] want_r;
  logic [1:0]           axis_r;
  logic signed [CW-1:0] best_r;
  logic                 hit_r;

  logic signed [CW-1:0] want_nxt;
  logic [1:0]           axis_nxt;
  logic signed [CW-1:0] best_nxt;
  logic                 hit_nxt;

  // widened operands
  logic signed [W-1:0] sb_w [6];
  logic signed [W-1:0] ob_w [6];
  logic signed [W-1:0] tol_w;
  logic signed [W-1:0] want_w;
  logic signed [W-1:0] best_w;

  logic [2:0]          ov;          // overlap on each axis with slack
  logic                side_ok;     // overlap on both cross axes
  logic                want_zero;
  logic                want_pos;
  logic signed [W-1:0] smin_a, smax_a, omin_a, omax_a;
  logic signed [W-1:0] sface, bface;
  logic                reach;
  logic signed [W-1:0] gap;
  logic signed [W-1:0] cand_raw;
  logic signed [W-1:0] cand;
  logic                better;
  logic                take;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sb_w[k] = {{2{sbox_r[k][CW-1]}}, sbox_r[k]};
      ob_w[k] = {{2{s1_box_r[k][CW-1]}}, s1_box_r[k]};
    end
    tol_w  = {{(W-TW){1'b0}}, tol_r};
    want_w = {{2{want_r[CW-1]}}, want_r};
    best_w = {{2{best_r[CW-1]}}, best_r};

    for (int k = 0; k < 3; k++) begin
      ov[k] = !((sb_w[k] >= ob_w[3+k] - tol_w) || (sb_w[3+k] <= ob_w[k] + tol_w));
    end
    side_ok = ((axis_r == sac_pkg::AXIS_X) || ov[0]) &&
              ((axis_r == sac_pkg::AXIS_Y) || ov[1]) &&
              ((axis_r == sac_pkg::AXIS_Z) || ov[2]);

    want_zero = (want_r == '0);
    want_pos  = !want_r[CW-1] && !want_zero;

    unique case (axis_r)
      sac_pkg::AXIS_X: begin
        smin_a = sb_w[0]; smax_a = sb_w[3]; omin_a = ob_w[0]; omax_a = ob_w[3];
      end
      sac_pkg::AXIS_Y: begin
        smin_a = sb_w[1]; smax_a = sb_w[4]; omin_a = ob_w[1]; omax_a = ob_w[4];
      end
      default: begin
        smin_a = sb_w[2]; smax_a = sb_w[5]; omin_a = ob_w[2]; omax_a = ob_w[5];
      end
    endcase

    // positive move meets the obstacle's low face, negative its high face
    if (want_pos) begin
      sface = smax_a;
      bface = omin_a;
      reach = !(sface > bface + tol_w) && !(sface + want_w < bface - tol_w);
    end else begin
      sface = smin_a;
      bface = omax_a;
      reach = !(sface < bface - tol_w) && !(sface + want_w > bface + tol_w);
    end

    gap      = bface - sface;
    cand_raw = want_pos ? (gap - tol_w) : (gap + tol_w);
    if (want_pos) begin
      cand   = cand_raw[W-1] ? '0 : cand_raw;
      better = !hit_r || (cand < best_w);
    end else begin
      cand   = cand_raw[W-1] ? cand_raw : '0;
      better = !hit_r || (cand > best_w);
    end

    take = s1_adv && (s1_op_r == sac_pkg::OP_BOX) && !want_zero && side_ok && reach;

    want_nxt = want_r;
    axis_nxt = axis_r;
    best_nxt = best_r;
    hit_nxt  = hit_r;
    if (s1_adv && (s1_op_r == sac_pkg::OP_BEGIN)) begin
      want_nxt = s1_delta_r;
      axis_nxt = (s1_axis_r > sac_pkg::AXIS_Z) ? sac_pkg::AXIS_Z : s1_axis_r;
      best_nxt = s1_delta_r;
      hit_nxt  = 1'b0;
    end else if (take) begin
      // candidate always lies between zero and the wanted move
      if (better) begin
        best_nxt = cand[CW-1:0];
      end
      hit_nxt = 1'b1;
    end
  end

  logic load_box;
  assign load_box = s1_adv && (s1_op_r == sac_pkg::OP_BEGIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      want_r <= '0;
      axis_r <= sac_pkg::AXIS_X;
      best_r <= '0;
      hit_r  <= 1'b0;
    end else begin
      want_r <= want_nxt;
      axis_r <= axis_nxt;
      best_r <= best_nxt;
      hit_r  <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_box) begin
      for (int k = 0; k < 6; k++) begin
        sbox_r[k] <= s1_box_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] res_delta_nxt, out_delta_r;
  logic                 res_hit_nxt, out_hit_r;
  logic                 res_gnd_nxt, out_gnd_r;
  logic                 res_zv_nxt, out_zv_r;
  logic                 out_valid_nxt;
  logic                 emit;

  assign emit = s1_adv && (s1_op_r == sac_pkg::OP_END);

  always_comb begin
    if (want_zero) begin
      // nothing asked for: no move, no flags
      res_delta_nxt = '0;
      res_hit_nxt   = 1'b0;
      res_gnd_nxt   = 1'b0;
      res_zv_nxt    = 1'b0;
    end else if (!s1_ok_r) begin
      // rejected query: stay put and stop
      res_delta_nxt = '0;
      res_hit_nxt   = 1'b0;
      res_gnd_nxt   = 1'b0;
      res_zv_nxt    = 1'b1;
    end else begin
      res_delta_nxt = best_r;
      res_hit_nxt   = hit_r;
      res_gnd_nxt   = hit_r && (axis_r == sac_pkg::AXIS_Y) && want_r[CW-1];
      res_zv_nxt    = hit_r;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_delta_r <= res_delta_nxt;
      out_hit_r   <= res_hit_nxt;
      out_gnd_r   <= res_gnd_nxt;
      out_zv_r    <= res_zv_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW-OUT_BITS){1'b0}}, out_zv_r, out_gnd_r, out_hit_r, out_delta_r};

endmodule

>>> design/sac_checker.sv
// port-level checks for the swept box axis clamp, bound to the top level
`timescale 1ns / 1ps

module sac_checker #(
  parameter int COORD_WIDTH = sac_pkg::COORD_WIDTH,
  localparam int OUT_BITS = COORD_WIDTH + 3,
  localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  localparam int CW = COORD_WIDTH;

  logic hit, gnd, zv;
  assign hit = out_tdata[CW];
  assign gnd = out_tdata[CW+1];
  assign zv  = out_tdata[CW+2];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // ground contact is a kind of hit
  a_ground: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && gnd |-> hit)
    else $error("ground without hit");

  // every hit clears velocity
  a_hit_zv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && hit |-> zv)
    else $error("hit without velocity clear");

  // a stop without a hit is a rejected query, which never moves
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && zv && !hit |-> (out_tdata[CW-1:0] == '0))
    else $error("rejected query moved");

endmodule

bind swept_aabb_axis_clamp sac_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
